### rtl/rc4_pkg.sv
package rc4_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 9;
    localparam int KEY_MAX_DEF = 256;
    localparam logic [LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic {
        OP_KEY  = 1'b0,
        OP_DATA = 1'b1
    } rc4_op_t;

endpackage

### rtl/rc4_stream_cipher.sv
// RC4 stream cipher on a streaming interface. An input request whose tuser bit is
// 0 stores a key byte. When the configured key length is reached, the block
// fills the permutation with identity and runs the key schedule, each step
// through the states KS_RD, KS_J, KS_W1 and KS_W2; s_tready is low meanwhile.
// It then clears both indices. A request whose tuser bit is 1 is a data byte:
// it passes through DG_RI, DG_RJ, DG_W1, DG_W2 and DG_OUT, which waits for
// the output register to empty, and gives one output request of data XOR
// keystream with tlast copied. The block returns to idle before the next
// request is taken, so it takes no new data byte until the last one is in the
// output register. After reset the permutation is filled with identity before
// the first request is taken; configuration writes are taken throughout. The
// permutation RAM, shared by every step, has one write port and one read port with registered read.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] value
    input  logic [0:0]       s_tuser,   // [0] opcode
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_out
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data
);

    localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam len_t KEY_MAX_L = LEN_W'(KEY_MAX);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_KS_RD = 4'd2;
    localparam logic [3:0] ST_KS_J  = 4'd3;
    localparam logic [3:0] ST_KS_W1 = 4'd4;
    localparam logic [3:0] ST_KS_W2 = 4'd5;
    localparam logic [3:0] ST_DG_RI = 4'd6;
    localparam logic [3:0] ST_DG_RJ = 4'd7;
    localparam logic [3:0] ST_DG_W1 = 4'd8;
    localparam logic [3:0] ST_DG_W2 = 4'd9;
    localparam logic [3:0] ST_DG_OUT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       init_ksa_reg, init_ksa_next;
    byte_t      k_reg, k_next;
    logic [KAW-1:0] kidx_reg, kidx_next;
    len_t       len_reg, len_next;
    len_t       key_length_reg;
    len_t       key_count_reg, key_count_next;
    byte_t      index_i_reg, index_i_next;
    byte_t      index_j_reg, index_j_next;
    byte_t      tmp_a_reg, tmp_a_next;
    byte_t      tmp_b_reg, tmp_b_next;
    logic       fwd_reg, fwd_next;
    byte_t      value_reg;
    logic       last_reg;
    logic       m_tvalid_reg, m_tvalid_next;
    byte_t      m_tdata_reg;
    logic       m_tlast_reg;
    logic       out_load;

    byte_t      perm_mem [256];
    byte_t      perm_rdata_reg;
    byte_t      perm_raddr, perm_waddr, perm_wdata;
    logic       perm_we;

    byte_t      key_mem [KEY_MAX];
    byte_t      key_rdata_reg;
    logic       key_we;
    logic [KAW-1:0] key_waddr;

    len_t       eff_len, kc_wrap, kc_inc;
    byte_t      sum_j, ks;
    logic       accept;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;

    always_comb begin
        if (key_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (key_length_reg > KEY_MAX_L) begin
            eff_len = KEY_MAX_L;
        end else begin
            eff_len = key_length_reg;
        end
        kc_wrap = (key_count_reg >= KEY_MAX_L) ? '0 : key_count_reg;
        kc_inc = kc_wrap + LEN_W'(1);
    end

    assign key_waddr = kc_wrap[KAW-1:0];
    assign key_we = accept && (s_tuser[0] == OP_KEY);
    assign ks = fwd_reg ? tmp_a_reg : perm_rdata_reg;
    assign out_load = (state_reg == ST_DG_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        init_ksa_next = init_ksa_reg;
        k_next = k_reg;
        kidx_next = kidx_reg;
        len_next = len_reg;
        key_count_next = key_count_reg;
        index_i_next = index_i_reg;
        index_j_next = index_j_reg;
        tmp_a_next = tmp_a_reg;
        tmp_b_next = tmp_b_reg;
        fwd_next = fwd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        perm_raddr = k_reg;
        perm_waddr = k_reg;
        perm_wdata = k_reg;
        perm_we = 1'b0;
        sum_j = index_j_reg + perm_rdata_reg + key_rdata_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == OP_KEY) begin
                        if (kc_inc >= eff_len) begin
                            len_next = eff_len;
                            key_count_next = '0;
                            init_ksa_next = 1'b1;
                            k_next = '0;
                            kidx_next = '0;
                            index_j_next = '0;
                            state_next = ST_INIT;
                        end else begin
                            key_count_next = kc_inc;
                        end
                    end else begin
                        state_next = ST_DG_RI;
                    end
                end
            end
            ST_INIT: begin
                perm_we = 1'b1;
                k_next = k_reg + 8'd1;
                if (k_reg == 8'd255) begin
                    state_next = init_ksa_reg ? ST_KS_RD : ST_IDLE;
                end
            end
            ST_KS_RD: begin
                state_next = ST_KS_J;
            end
            ST_KS_J: begin
                tmp_a_next = perm_rdata_reg;
                index_j_next = sum_j;
                perm_raddr = sum_j;
                state_next = ST_KS_W1;
            end
            ST_KS_W1: begin
                perm_we = 1'b1;
                perm_wdata = perm_rdata_reg;
                state_next = ST_KS_W2;
            end
            ST_KS_W2: begin
                perm_we = 1'b1;
                perm_waddr = index_j_reg;
                perm_wdata = tmp_a_reg;
                k_next = k_reg + 8'd1;
                if (LEN_W'(kidx_reg) + LEN_W'(1) == len_reg) begin
                    kidx_next = '0;
                end else begin
                    kidx_next = kidx_reg + KAW'(1);
                end
                if (k_reg == 8'd255) begin
                    index_i_next = '0;
                    index_j_next = '0;
                    key_count_next = '0;
                    init_ksa_next = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_KS_RD;
                end
            end
            ST_DG_RI: begin
                index_i_next = index_i_reg + 8'd1;
                perm_raddr = index_i_reg + 8'd1;
                state_next = ST_DG_RJ;
            end
            ST_DG_RJ: begin
                tmp_a_next = perm_rdata_reg;
                index_j_next = index_j_reg + perm_rdata_reg;
                perm_raddr = index_j_reg + perm_rdata_reg;
                state_next = ST_DG_W1;
            end
            ST_DG_W1: begin
                tmp_b_next = perm_rdata_reg;
                perm_we = 1'b1;
                perm_waddr = index_i_reg;
                perm_wdata = perm_rdata_reg;
                state_next = ST_DG_W2;
            end
            ST_DG_W2: begin
                perm_we = 1'b1;
                perm_waddr = index_j_reg;
                perm_wdata = tmp_a_reg;
                perm_raddr = tmp_a_reg + tmp_b_reg;
                // read meets the write to S[j] in the same cycle
                fwd_next = ((tmp_a_reg + tmp_b_reg) == index_j_reg);
                state_next = ST_DG_OUT;
            end
            ST_DG_OUT: begin
                // keep the keystream read in place while the output is held
                perm_raddr = tmp_a_reg + tmp_b_reg;
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            init_ksa_reg <= 1'b0;
            k_reg <= '0;
            kidx_reg <= '0;
            len_reg <= LEN_W'(1);
            key_length_reg <= KEY_LEN_RESET;
            key_count_reg <= '0;
            index_i_reg <= '0;
            index_j_reg <= '0;
            fwd_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            init_ksa_reg <= init_ksa_next;
            k_reg <= k_next;
            kidx_reg <= kidx_next;
            len_reg <= len_next;
            if (cfg_valid && cfg_ready) begin
                key_length_reg <= cfg_data;
            end
            key_count_reg <= key_count_next;
            index_i_reg <= index_i_next;
            index_j_reg <= index_j_next;
            fwd_reg <= fwd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tmp_a_reg <= tmp_a_next;
        tmp_b_reg <= tmp_b_next;
        if (accept) begin
            value_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (out_load) begin
            m_tdata_reg <= value_reg ^ ks;
            m_tlast_reg <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (perm_we) begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        perm_rdata_reg <= perm_mem[perm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= s_tdata;
        end
        key_rdata_reg <= key_mem[kidx_reg];
    end

    a_data_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser[0] != OP_KEY) |=> ##4 (state_reg == ST_DG_OUT))
        else $error("data request did not reach output stage on time");

    a_ksa_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KS_W2 && k_reg == 8'd255) |=>
        (index_i_reg == '0 && index_j_reg == '0 && key_count_reg == '0))
        else $error("indices not cleared after key schedule");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("pending output overwritten");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rc4_pkg::*;

    typedef struct packed {
        byte_t data_out;
        logic  last_out;
    } cipher_result_t;

    // covers the key schedule that a key byte may have started
    localparam int SETTLE_CYCLES = 1500;

    class keystream_model;
        byte_t          sbox[256];
        byte_t          key_bytes[KEY_MAX_DEF];
        byte_t          idx_i;
        byte_t          idx_j;
        int unsigned    key_count;
        len_t           key_len;
        cipher_result_t expected_bytes[$];
        int unsigned    mismatches;

        function new();
            int k;
            for (k = 0; k < 256; k++) sbox[k] = byte_t'(k);
            for (k = 0; k < KEY_MAX_DEF; k++) key_bytes[k] = '0;
            idx_i      = '0;
            idx_j      = '0;
            key_count  = 0;
            key_len    = KEY_LEN_RESET;
            mismatches = 0;
        endfunction

        function int unsigned usable_length();
            int unsigned len;
            len = key_len;
            if (len == 0) len = 1;
            if (len > KEY_MAX_DEF) len = KEY_MAX_DEF;
            return len;
        endfunction

        function void run_key_schedule(int unsigned len);
            int unsigned k;
            byte_t j;
            byte_t t;
            j = '0;
            for (k = 0; k < 256; k++) sbox[k] = byte_t'(k);
            for (k = 0; k < 256; k++) begin
                j       = j + sbox[k] + key_bytes[(k % len) % KEY_MAX_DEF];
                t       = sbox[k];
                sbox[k] = sbox[j];
                sbox[j] = t;
            end
            idx_i     = '0;
            idx_j     = '0;
            key_count = 0;
        endfunction

        function void note_request(rc4_op_t op, byte_t val, logic lst);
            int unsigned len;
            byte_t t;
            byte_t sum;
            cipher_result_t res;
            if (op == OP_KEY) begin
                len = usable_length();
                if (key_count >= KEY_MAX_DEF) key_count = 0;
                key_bytes[key_count % KEY_MAX_DEF] = val;
                key_count = (key_count + 1) & 9'h1FF;
                if (key_count >= len) run_key_schedule(len);
            end else begin
                idx_i       = idx_i + 8'd1;
                idx_j       = idx_j + sbox[idx_i];
                t           = sbox[idx_i];
                sbox[idx_i] = sbox[idx_j];
                sbox[idx_j] = t;
                sum          = sbox[idx_i] + sbox[idx_j];
                res.data_out = val ^ sbox[sum];
                res.last_out = lst;
                expected_bytes.push_back(res);
            end
        endfunction

        function void check_result(byte_t data, logic lst);
            cipher_result_t want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected result: data_out=%02h last_out=%0b", data, lst);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (data !== want.data_out) begin
                    $error("data_out: expected %02h, got %02h", want.data_out, data);
                    mismatches++;
                end
                if (lst !== want.last_out) begin
                    $error("last_out: expected %0b, got %0b", want.last_out, lst);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = '0;     // [7:0] value
    logic [0:0] s_tuser   = '0;     // [0] opcode
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // [7:0] data_out
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    len_t       cfg_data  = '0;

    keystream_model cipher_sb = new();
    int unsigned    items_sent   = 0;
    int unsigned    results_seen = 0;
    bit             src_steady   = 1'b0;
    bit             sink_steady  = 1'b0;

    rc4_stream_cipher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            cipher_sb.check_result(m_tdata, m_tlast);
            results_seen++;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input rc4_op_t op, input byte_t val, input logic lst);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cipher_sb.note_request(op, val, lst);
        items_sent++;
    endtask

    task automatic send_key(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_byte(OP_KEY, byte_t'($urandom_range(0, 255)), logic'($urandom_range(0, 1)));
    endtask

    task automatic send_burst(input int n);
        int k;
        for (k = 0; k < n; k++)
            send_byte(OP_DATA, byte_t'($urandom_range(0, 255)),
                      (k == n - 1) || ($urandom_range(0, 9) == 0));
    endtask

    // mostly a whole key then a buffer of data, now and then a jumble of both
    task automatic run_messages(input int count);
        int m;
        int k;
        for (m = 0; m < count; m++) begin
            src_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 80) begin
                send_key(cipher_sb.usable_length());
                send_burst($urandom_range(1, 24));
            end else begin
                for (k = $urandom_range(3, 8); k > 0; k--)
                    send_byte(rc4_op_t'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                              logic'($urandom_range(0, 1)));
            end
        end
        src_steady = 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (cipher_sb.expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_key_length(input len_t len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cipher_sb.key_len = len;
    endtask

    initial begin : result_sink
        int n;
        int unsigned next_hold;
        next_hold = 60;
        @(posedge aclk);
        forever begin
            if (results_seen >= next_hold) begin
                // long hold-off so the output register fills and s_tready drops
                next_hold += 200;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                if ($urandom_range(0, 199) == 0) sink_steady = !sink_steady;
                n = sink_steady ? 0 : pick_gap();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int n;
        len_t len;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // no key yet: identity permutation
        send_byte(OP_DATA, 8'h00, 1'b0);
        send_byte(OP_DATA, 8'hFF, 1'b1);
        send_byte(OP_DATA, 8'hA5, 1'b0);
        // full key at the reset length, tlast on a key byte is ignored
        send_byte(OP_KEY, 8'h00, 1'b1);
        send_byte(OP_KEY, 8'hFF, 1'b0);
        for (n = 2; n < 16; n++) send_byte(OP_KEY, byte_t'(n * 17), n[0]);
        send_byte(OP_DATA, 8'h00, 1'b1);
        send_byte(OP_DATA, 8'hFF, 1'b0);
        // length lowered part-way through a key
        for (n = 0; n < 5; n++) send_byte(OP_KEY, byte_t'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        write_key_length(9'd3);
        send_byte(OP_KEY, 8'h3C, 1'b0);
        send_byte(OP_DATA, 8'h81, 1'b1);
        send_byte(OP_DATA, 8'h7E, 1'b0);

        // all ones clips to a 256-byte key
        wait_idle();
        write_key_length(9'h1FF);
        send_key(256);
        send_burst(30);
        wait_idle();
        write_key_length(9'd256);
        send_key(12);
        send_burst(10);
        // zero acts as one, and completes the partial key
        wait_idle();
        write_key_length(9'd0);
        send_key(1);
        send_burst(10);
        wait_idle();
        write_key_length(9'd257);
        send_key(7);
        send_burst(8);
        wait_idle();
        write_key_length(9'd1);
        run_messages(6);

        while (items_sent < 800) begin
            wait_idle();
            if ($urandom_range(0, 9) < 3)
                len = len_t'($urandom_range(1, 3));
            else
                len = len_t'($urandom_range(4, 24));
            write_key_length(len);
            run_messages($urandom_range(4, 10));
        end

        wait_idle();
        if (cipher_sb.mismatches == 0 && cipher_sb.expected_bytes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/rc4_pkg.sv
rtl/rc4_stream_cipher.sv
tb/testbench.sv
